@@ src/scc_pkg.sv @@
// ----------------------------------------------------------------------------
// scc_pkg
// Shared types and constants for the strongly connected components search.
// ----------------------------------------------------------------------------
package scc_pkg;

	// Node numbers, edge links and a stored call frame.
	localparam int NODE_W  = 7;
	localparam int LINK_W  = 11;
	localparam int FRAME_W = 3 * NODE_W + LINK_W;
	localparam int EDGE_W  = NODE_W + LINK_W;

	// Request kinds carried on the input tuser.
	localparam logic REQ_ADD = 1'b0;
	localparam logic REQ_RUN = 1'b1;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ADD,
		ST_ROOT,
		ST_ENTER,
		ST_STEP,
		ST_EDGE,
		ST_CMP,
		ST_RET,
		ST_RET2,
		ST_POP,
		ST_POP2,
		ST_FLUSH,
		ST_CLEAR
	} state_t;

	// One result item.
	typedef struct packed {
		logic              dropped;
		logic              last_run;
		logic              last_comp;
		logic [NODE_W-1:0] node;
		logic [NODE_W-1:0] comp;
	} result_t;

endpackage

@@ src/strongly_connected_components.sv @@
// ----------------------------------------------------------------------------
// strongly_connected_components
// Tarjan search over a loaded directed graph with memory-held state.
// ----------------------------------------------------------------------------
// An add request (tuser 0) first reads the head of the source node's list and
// then links the new edge in front of it; a dropped add is not linked. A run
// request (tuser 1) walks the graph through a single sequencer that shares one
// read port per memory: each edge is read and then skipped, followed into a new
// node, or compared against a node already visited; each node is entered and
// closed, each node popped into a component is read back off the stack, and
// each root is checked. At the end the flush state sends the last result and
// the clear state clears all stores. A stalled receiver holds the search
// whenever both the output register and the pending result are full.
// Results leave through an output register; the last result of a run carries
// tlast. Adjacency heads, visit marks and on-stack marks are flip-flop valid
// bits, so clearing after a run needs no memory writes.
module strongly_connected_components #(
	parameter int MAX_NODES = 64,
	parameter int MAX_EDGES = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration: node_count.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [6:0]  cfg_data,
	// Input requests.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // edge_from[6:0], edge_to[13:7], zeros
	input  logic        s_tuser,  // req_type
	// Results.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // component_index[6:0], member_node[13:7], zeros
	output logic [1:0]  m_tuser,  // last_of_component[0], edges_dropped[1]
	output logic        m_tlast   // last_of_run
);

	localparam int NW     = scc_pkg::NODE_W;
	localparam int LW     = scc_pkg::LINK_W;
	localparam int NAW    = $clog2(MAX_NODES);
	localparam int DW     = $clog2(MAX_NODES + 1);
	localparam int EAW    = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;

	scc_pkg::state_t state_q, state_d;

	logic [NW-1:0]        cfg_q, n_eff;
	logic [LW-1:0]        etot_q;
	logic                 drop_q;
	logic [NW-1:0]        a_q, b_q, root_q, x_q, y_q, low_q, vis_q, clow_q;
	logic [NW-1:0]        vcnt_q, ccnt_q;
	logic [LW-1:0]        e_q;
	logic [DW-1:0]        fdep_q, sdep_q;
	logic [MAX_NODES-1:0] hv_q, vv_q, onstk_q;
	scc_pkg::result_t     pend_q, out_q;
	logic                 pv_q, m_tvalid_q;

	logic [NW-1:0] in_from, in_to;
	logic          add_ok;

	// Memory ports.
	logic                       head_we;
	logic [NAW-1:0]             head_waddr, head_raddr;
	logic [LW-1:0]              head_wdata, head_rd, head_eff;
	logic                       edge_we;
	logic [EAW-1:0]             edge_waddr, edge_raddr;
	logic [scc_pkg::EDGE_W-1:0] edge_wdata, edge_rd;
	logic [NW-1:0]              tgt;
	logic [LW-1:0]              lnk;
	logic                       vis_we;
	logic [NAW-1:0]             vis_waddr, vis_raddr;
	logic [NW-1:0]              vis_wdata, vis_rd;
	logic                       stk_we;
	logic [NAW-1:0]             stk_waddr, stk_raddr;
	logic [NW-1:0]              stk_wdata, stk_rd;
	logic                       frm_we;
	logic [NAW-1:0]             frm_waddr, frm_raddr;
	logic [scc_pkg::FRAME_W-1:0] frm_wdata, frm_rd;
	logic [NW-1:0]              frm_x, frm_low, frm_vis;
	logic [LW-1:0]              frm_e;

	logic [DW-1:0] fdep_m1, sdep_m1;
	logic [LW-1:0] e_m1;
	logic          out_free, pop_go, flush_go, out_load;
	logic [NW-1:0] vcnt_p1;

	// Node number to memory address.
	function automatic logic [NAW-1:0] naddr(input logic [NW-1:0] v);
		logic [NW-1:0] d;
		d = v - NW'(1);
		return d[NAW-1:0];
	endfunction

	assign n_eff    = (cfg_q > NW'(MAX_NODES)) ? NW'(MAX_NODES) : cfg_q;
	assign in_from  = s_tdata[6:0];
	assign in_to    = s_tdata[13:7];
	assign add_ok   = (in_from != '0) && (in_from <= n_eff) && (in_to != '0)
		&& (in_to <= n_eff) && (etot_q < LW'(MAX_EDGES));
	assign tgt      = edge_rd[scc_pkg::EDGE_W-1:LW];
	assign lnk      = edge_rd[LW-1:0];
	assign frm_x    = frm_rd[scc_pkg::FRAME_W-1 -: NW];
	assign frm_e    = frm_rd[2*NW +: LW];
	assign frm_low  = frm_rd[2*NW-1 -: NW];
	assign frm_vis  = frm_rd[NW-1:0];
	assign fdep_m1  = fdep_q - DW'(1);
	assign sdep_m1  = sdep_q - DW'(1);
	assign e_m1     = e_q - LW'(1);
	assign vcnt_p1  = vcnt_q + NW'(1);
	assign out_free = !m_tvalid_q || m_tready;
	assign pop_go   = (state_q == scc_pkg::ST_POP2) && (!pv_q || out_free);
	assign flush_go = (state_q == scc_pkg::ST_FLUSH) && pv_q && out_free;
	assign out_load = (pop_go && pv_q) || flush_go;

	// An unwritten head reads as an empty list.
	always_comb begin
		if (state_q == scc_pkg::ST_ADD) begin
			head_eff = hv_q[naddr(a_q)] ? head_rd : '0;
		end else begin
			head_eff = hv_q[naddr(y_q)] ? head_rd : '0;
		end
	end

	// Memory control.
	always_comb begin
		head_we    = (state_q == scc_pkg::ST_ADD);
		head_waddr = naddr(a_q);
		head_wdata = etot_q + LW'(1);
		unique case (state_q)
			scc_pkg::ST_IDLE: head_raddr = naddr(in_from);
			scc_pkg::ST_ROOT: head_raddr = naddr(root_q);
			scc_pkg::ST_EDGE: head_raddr = naddr(tgt);
			default:          head_raddr = naddr(y_q);
		endcase
		edge_we    = (state_q == scc_pkg::ST_ADD);
		edge_waddr = etot_q[EAW-1:0];
		edge_wdata = {b_q, head_eff};
		edge_raddr = e_m1[EAW-1:0];
		vis_we     = (state_q == scc_pkg::ST_ENTER);
		vis_waddr  = naddr(y_q);
		vis_wdata  = vcnt_p1;
		vis_raddr  = naddr(tgt);
		stk_we     = (state_q == scc_pkg::ST_ENTER);
		stk_waddr  = sdep_q[NAW-1:0];
		stk_wdata  = y_q;
		stk_raddr  = sdep_m1[NAW-1:0];
		frm_we     = (state_q == scc_pkg::ST_ENTER) && (fdep_q != '0);
		frm_waddr  = fdep_m1[NAW-1:0];
		frm_wdata  = {x_q, e_q, low_q, vis_q};
		frm_raddr  = fdep_m1[NAW-1:0];
	end

	scc_ram #(.DEPTH(MAX_NODES), .WIDTH(LW)) u_head (
		.clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
		.raddr(head_raddr), .rdata(head_rd)
	);

	scc_ram #(.DEPTH(MAX_EDGES), .WIDTH(scc_pkg::EDGE_W)) u_edge (
		.clk(clk), .we(edge_we), .waddr(edge_waddr), .wdata(edge_wdata),
		.raddr(edge_raddr), .rdata(edge_rd)
	);

	scc_ram #(.DEPTH(MAX_NODES), .WIDTH(NW)) u_visit (
		.clk(clk), .we(vis_we), .waddr(vis_waddr), .wdata(vis_wdata),
		.raddr(vis_raddr), .rdata(vis_rd)
	);

	scc_ram #(.DEPTH(MAX_NODES), .WIDTH(NW)) u_stack (
		.clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
		.raddr(stk_raddr), .rdata(stk_rd)
	);

	scc_ram #(.DEPTH(MAX_NODES), .WIDTH(scc_pkg::FRAME_W)) u_frame (
		.clk(clk), .we(frm_we), .waddr(frm_waddr), .wdata(frm_wdata),
		.raddr(frm_raddr), .rdata(frm_rd)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			scc_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					if (s_tuser == scc_pkg::REQ_RUN) begin
						state_d = scc_pkg::ST_ROOT;
					end else if (add_ok) begin
						state_d = scc_pkg::ST_ADD;
					end
				end
			end
			scc_pkg::ST_ADD:   state_d = scc_pkg::ST_IDLE;
			scc_pkg::ST_ROOT: begin
				if (root_q > n_eff) begin
					state_d = scc_pkg::ST_FLUSH;
				end else if (!vv_q[naddr(root_q)]) begin
					state_d = scc_pkg::ST_ENTER;
				end
			end
			scc_pkg::ST_ENTER: state_d = scc_pkg::ST_STEP;
			scc_pkg::ST_STEP: begin
				if (e_q != '0) begin
					state_d = scc_pkg::ST_EDGE;
				end else if (low_q == vis_q) begin
					state_d = scc_pkg::ST_POP;
				end else begin
					state_d = scc_pkg::ST_RET;
				end
			end
			scc_pkg::ST_EDGE: begin
				if (tgt == '0 || tgt > n_eff) begin
					state_d = scc_pkg::ST_STEP;
				end else if (!vv_q[naddr(tgt)]) begin
					state_d = scc_pkg::ST_ENTER;
				end else begin
					state_d = scc_pkg::ST_CMP;
				end
			end
			scc_pkg::ST_CMP:   state_d = scc_pkg::ST_STEP;
			scc_pkg::ST_RET: begin
				state_d = (fdep_q == '0) ? scc_pkg::ST_ROOT : scc_pkg::ST_RET2;
			end
			scc_pkg::ST_RET2:  state_d = scc_pkg::ST_STEP;
			scc_pkg::ST_POP:   state_d = scc_pkg::ST_POP2;
			scc_pkg::ST_POP2: begin
				if (pop_go) begin
					state_d = (stk_rd == x_q) ? scc_pkg::ST_RET : scc_pkg::ST_POP;
				end
			end
			scc_pkg::ST_FLUSH: begin
				if (!pv_q || out_free) begin
					state_d = scc_pkg::ST_CLEAR;
				end
			end
			scc_pkg::ST_CLEAR: state_d = scc_pkg::ST_IDLE;
			default:           state_d = scc_pkg::ST_IDLE;
		endcase
	end

	// Handshake outputs.
	always_comb begin
		s_tready  = (state_q == scc_pkg::ST_IDLE);
		cfg_ready = 1'b1;
		m_tvalid  = m_tvalid_q;
		m_tdata   = {2'b00, out_q.node, out_q.comp};
		m_tuser   = {out_q.dropped, out_q.last_comp};
		m_tlast   = out_q.last_run;
	end

	// Control and search state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= scc_pkg::ST_IDLE;
			cfg_q      <= NW'(64);
			etot_q     <= '0;
			drop_q     <= 1'b0;
			vcnt_q     <= '0;
			ccnt_q     <= '0;
			fdep_q     <= '0;
			sdep_q     <= '0;
			hv_q       <= '0;
			vv_q       <= '0;
			onstk_q    <= '0;
			pv_q       <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				cfg_q <= cfg_data;
			end
			unique case (state_q)
				scc_pkg::ST_IDLE: begin
					if (s_tvalid && s_tuser == scc_pkg::REQ_ADD && !add_ok) begin
						drop_q <= 1'b1;
					end
				end
				scc_pkg::ST_ADD: begin
					etot_q            <= etot_q + LW'(1);
					hv_q[naddr(a_q)]  <= 1'b1;
				end
				scc_pkg::ST_ENTER: begin
					vcnt_q            <= vcnt_p1;
					vv_q[naddr(y_q)]  <= 1'b1;
					onstk_q[naddr(y_q)] <= 1'b1;
					sdep_q            <= sdep_q + DW'(1);
					fdep_q            <= fdep_q + DW'(1);
				end
				scc_pkg::ST_STEP: begin
					if (e_q == '0) begin
						fdep_q <= fdep_m1;
						if (low_q == vis_q) begin
							ccnt_q <= ccnt_q + NW'(1);
						end
					end
				end
				scc_pkg::ST_POP2: begin
					if (pop_go) begin
						onstk_q[naddr(stk_rd)] <= 1'b0;
						sdep_q                 <= sdep_m1;
						pv_q                   <= 1'b1;
					end
				end
				scc_pkg::ST_FLUSH: begin
					if (flush_go) begin
						pv_q <= 1'b0;
					end
				end
				scc_pkg::ST_CLEAR: begin
					etot_q  <= '0;
					drop_q  <= 1'b0;
					vcnt_q  <= '0;
					ccnt_q  <= '0;
					fdep_q  <= '0;
					sdep_q  <= '0;
					hv_q    <= '0;
					vv_q    <= '0;
					onstk_q <= '0;
				end
				default: begin
				end
			endcase
			if (out_free) begin
				m_tvalid_q <= out_load;
			end
		end
	end

	// Payload and working registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			scc_pkg::ST_IDLE: begin
				a_q    <= in_from;
				b_q    <= in_to;
				root_q <= NW'(1);
			end
			scc_pkg::ST_ROOT: begin
				y_q <= root_q;
				if (root_q <= n_eff && vv_q[naddr(root_q)]) begin
					root_q <= root_q + NW'(1);
				end
			end
			scc_pkg::ST_ENTER: begin
				x_q   <= y_q;
				e_q   <= head_eff;
				low_q <= vcnt_p1;
				vis_q <= vcnt_p1;
			end
			scc_pkg::ST_STEP: begin
				clow_q <= low_q;
			end
			scc_pkg::ST_EDGE: begin
				e_q <= lnk;
				y_q <= tgt;
			end
			scc_pkg::ST_CMP: begin
				if (onstk_q[naddr(y_q)] && vis_rd < low_q) begin
					low_q <= vis_rd;
				end
			end
			scc_pkg::ST_RET: begin
				if (fdep_q == '0) begin
					root_q <= root_q + NW'(1);
				end
			end
			scc_pkg::ST_RET2: begin
				x_q   <= frm_x;
				e_q   <= frm_e;
				vis_q <= frm_vis;
				low_q <= (clow_q < frm_low) ? clow_q : frm_low;
			end
			scc_pkg::ST_POP2: begin
				if (pop_go) begin
					pend_q.comp      <= ccnt_q;
					pend_q.node      <= stk_rd;
					pend_q.last_comp <= (stk_rd == x_q);
					pend_q.last_run  <= 1'b0;
					pend_q.dropped   <= drop_q;
				end
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_q          <= pend_q;
			out_q.last_run <= flush_go;
		end
	end

`ifndef ASSERT_OFF
	// Every node on the frame stack is also on the node stack.
	a_frames_within_stack: assert property (@(posedge clk) disable iff (!arst_n)
		fdep_q <= sdep_q)
		else $error("frame depth exceeds node stack depth");

	// The node stack never holds more than the node capacity.
	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sdep_q <= DW'(MAX_NODES))
		else $error("node stack overflow");

	// Between runs both stacks are empty.
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == scc_pkg::ST_IDLE |-> (fdep_q == '0 && sdep_q == '0 && !pv_q))
		else $error("stack or pending result left over after a run");
`endif

endmodule

@@ src/scc_ram.sv @@
// ----------------------------------------------------------------------------
// scc_ram
// Simple dual-port synchronous memory, one write and one registered read.
// ----------------------------------------------------------------------------
module scc_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 8
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

@@ verif/strongly_connected_components_tb.sv @@
// ----------------------------------------------------------------------------
// strongly_connected_components_tb
// Self-checking bench for the Tarjan component search block.
// ----------------------------------------------------------------------------
// Graphs are loaded edge by edge and searched with run requests. A behavioral
// model of the search, kept inside the bench, predicts every component member
// in pop order. A short table of directed requests covers the node count
// extremes, dropped edges, an empty run and a count lowered after loading.
// Random graphs follow, mostly well formed with some out-of-range noise. Both
// stream sides idle in short random bursts, and the receiver once holds off
// long enough to back up the input.
// ----------------------------------------------------------------------------
module strongly_connected_components_tb;

	localparam int NODES_MAX  = 64;
	localparam int EDGES_MAX  = 1024;
	localparam int SETTLE     = 64;
	localparam int CYCLE_CAP  = 1000000;
	localparam int REPORT_MAX = 10;

	typedef enum int {ROW_CFG, ROW_ADD, ROW_RUN} row_kind_t;

	typedef struct {
		row_kind_t        kind;
		int               a;
		int               b;
		bit               typed;
		scc_pkg::result_t want;
	} plan_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [6:0]  cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	// Shadow copy of the graph and search state.
	logic [6:0]  node_limit;
	logic [10:0] list_head  [NODES_MAX+1];
	logic [6:0]  arc_target [EDGES_MAX+1];
	logic [10:0] arc_next   [EDGES_MAX+1];
	int          arc_count;
	logic [6:0]  order_of   [NODES_MAX+1];
	logic [6:0]  low_of     [NODES_MAX+1];
	bit          stacked    [NODES_MAX+1];
	logic [6:0]  pop_stack  [NODES_MAX];
	logic [6:0]  walk_node  [NODES_MAX];
	logic [10:0] walk_arc   [NODES_MAX];
	int          pop_depth;
	int          walk_depth;
	logic [6:0]  order_count;
	logic [6:0]  comp_count;
	bit          dropped_any;

	scc_pkg::result_t pending_members[$];
	plan_row_t   plan[$];
	int          mismatches;
	int          members_seen;
	int          requests_sent;
	int          searches_sent;
	int          cycles;
	int          hold_left;
	int          ready_gap;
	bit          calm;

	strongly_connected_components i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	// Clock.
	always #1 clk = ~clk;

	// Empty the graph and search state.
	function automatic void wipe_graph();
		for (int i = 0; i <= NODES_MAX; i++) begin
			list_head[i] = '0;
			order_of[i]  = '0;
			low_of[i]    = '0;
			stacked[i]   = 0;
		end
		arc_count   = 0;
		pop_depth   = 0;
		walk_depth  = 0;
		order_count = '0;
		comp_count  = '0;
		dropped_any = 0;
	endfunction

	function automatic int live_nodes();
		return (node_limit > NODES_MAX) ? NODES_MAX : int'(node_limit);
	endfunction

	// Link one edge at the head of its source list, or drop it.
	function automatic void link_edge(int a, int b);
		int n;
		n = live_nodes();
		if (a < 1 || a > n || b < 1 || b > n || arc_count >= EDGES_MAX) begin
			dropped_any = 1;
		end else begin
			arc_count++;
			arc_target[arc_count] = b[6:0];
			arc_next[arc_count]   = list_head[a];
			list_head[a]          = arc_count[10:0];
		end
	endfunction

	// Visit a node: number it, push it and open a frame for it.
	function automatic void visit(logic [6:0] x);
		if (walk_depth < NODES_MAX && pop_depth < NODES_MAX) begin
			order_count          = order_count + 7'd1;
			order_of[x]          = order_count;
			low_of[x]            = order_count;
			pop_stack[pop_depth] = x;
			pop_depth++;
			stacked[x]           = 1;
			walk_node[walk_depth] = x;
			walk_arc[walk_depth]  = list_head[x];
			walk_depth++;
		end
	endfunction

	// Pop one closed component down to its root x.
	function automatic void close_component(logic [6:0] x,
		ref scc_pkg::result_t found[$]);
		logic [6:0]       w;
		scc_pkg::result_t r;
		comp_count = comp_count + 7'd1;
		do begin
			if (pop_depth == 0)
				break;
			pop_depth--;
			w = pop_stack[pop_depth];
			stacked[w]  = 0;
			r.comp      = comp_count;
			r.node      = w;
			r.last_comp = (w == x);
			r.last_run  = 1'b0;
			r.dropped   = dropped_any;
			found.push_back(r);
		end while (w != x);
	endfunction

	// Full search from node 1 upward, then clear everything.
	function automatic void search_graph(ref scc_pkg::result_t found[$]);
		int          n;
		logic [6:0]  x;
		logic [6:0]  y;
		logic [6:0]  p;
		logic [10:0] e;
		n = live_nodes();
		for (int root = 1; root <= n; root++) begin
			if (order_of[root] != 0)
				continue;
			visit(root[6:0]);
			while (walk_depth > 0) begin
				x = walk_node[walk_depth-1];
				e = walk_arc[walk_depth-1];
				if (e != 0) begin
					y = arc_target[e];
					walk_arc[walk_depth-1] = arc_next[e];
					if (y < 1 || y > n)
						continue;
					if (order_of[y] == 0)
						visit(y);
					else if (stacked[y] && order_of[y] < low_of[x])
						low_of[x] = order_of[y];
				end else begin
					walk_depth--;
					if (low_of[x] == order_of[x])
						close_component(x, found);
					if (walk_depth > 0) begin
						p = walk_node[walk_depth-1];
						if (low_of[x] < low_of[p])
							low_of[p] = low_of[x];
					end
				end
			end
		end
		if (found.size() > 0)
			found[found.size()-1].last_run = 1'b1;
		wipe_graph();
	endfunction

	// Offer one request and fold it into the model once it is taken.
	task automatic send_request(logic kind, int a, int b, bit typed,
		scc_pkg::result_t want);
		scc_pkg::result_t found[$];
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {2'b00, b[6:0], a[6:0]};
		do @(posedge clk); while (!s_tready);
		requests_sent++;
		if (kind == scc_pkg::REQ_ADD) begin
			link_edge(a, b);
		end else begin
			searches_sent++;
			search_graph(found);
			if (typed)
				found = '{want};
			foreach (found[i])
				pending_members.push_back(found[i]);
		end
	endtask

	// Wait until every member has come back and the block has settled.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending_members.size() > 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Write the node count register; only called while the block is idle.
	task automatic write_count(int value);
		cfg_valid <= 1'b1;
		cfg_data  <= value[6:0];
		do @(posedge clk); while (!cfg_ready);
		cfg_valid  <= 1'b0;
		node_limit = value[6:0];
	endtask

	// One random graph: mostly in-range edges, some noise, then a search.
	task automatic random_graph(int n, int edges);
		int a;
		int b;
		for (int i = 0; i < edges; i++) begin
			if ($urandom_range(0, 9) == 0) begin
				a = $urandom_range(0, 127);
				b = $urandom_range(0, 127);
			end else begin
				a = $urandom_range(1, n);
				b = $urandom_range(1, n);
			end
			send_request(scc_pkg::REQ_ADD, a, b, 0, '0);
		end
		send_request(scc_pkg::REQ_RUN, 0, 0, 0, '0);
	endtask

	// Result checker.
	always @(posedge clk) begin
		scc_pkg::result_t got;
		scc_pkg::result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.comp      = m_tdata[6:0];
			got.node      = m_tdata[13:7];
			got.last_comp = m_tuser[0];
			got.dropped   = m_tuser[1];
			got.last_run  = m_tlast;
			members_seen++;
			if (pending_members.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("unexpected member: comp %0d node %0d", got.comp, got.node);
			end else begin
				want = pending_members.pop_front();
				if (got.comp !== want.comp || got.node !== want.node ||
				    got.last_comp !== want.last_comp || got.last_run !== want.last_run ||
				    got.dropped !== want.dropped) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display({"member mismatch: exp comp %0d node %0d lc %0b lr %0b dr %0b,",
							" got comp %0d node %0d lc %0b lr %0b dr %0b"},
							want.comp, want.node, want.last_comp, want.last_run, want.dropped,
							got.comp, got.node, got.last_comp, got.last_run, got.dropped);
				end
			end
		end
	end

	// Receiver: short random stalls, plus one long hold when asked.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else if (ready_gap > 0) begin
			m_tready <= 1'b0;
			ready_gap--;
		end else if (!calm && $urandom_range(0, 4) == 0) begin
			m_tready <= 1'b0;
			ready_gap = $urandom_range(0, 3);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("timeout with %0d members outstanding", pending_members.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Stimulus.
	initial begin
		int n;
		clk = 0;
		arst_n = 0;
		cfg_valid = 0;
		cfg_data = '0;
		s_tvalid = 0;
		s_tdata = '0;
		s_tuser = scc_pkg::REQ_ADD;
		m_tready = 0;
		mismatches = 0;
		members_seen = 0;
		requests_sent = 0;
		searches_sent = 0;
		cycles = 0;
		hold_left = 0;
		ready_gap = 0;
		calm = 0;
		node_limit = 7'd64;
		wipe_graph();

		// Directed requests; typed rows are single-node runs.
		plan.push_back('{ROW_CFG, 1, 0, 0, '0});
		plan.push_back('{ROW_RUN, 0, 0, 1,
			scc_pkg::result_t'{1'b0, 1'b1, 1'b1, 7'd1, 7'd1}});
		plan.push_back('{ROW_ADD, 1, 2, 0, '0});
		plan.push_back('{ROW_RUN, 0, 0, 1,
			scc_pkg::result_t'{1'b1, 1'b1, 1'b1, 7'd1, 7'd1}});
		plan.push_back('{ROW_CFG, 0, 0, 0, '0});
		plan.push_back('{ROW_ADD, 0, 0, 0, '0});
		plan.push_back('{ROW_RUN, 0, 0, 0, '0});
		plan.push_back('{ROW_CFG, 127, 0, 0, '0});
		plan.push_back('{ROW_ADD, 64, 64, 0, '0});
		plan.push_back('{ROW_ADD, 1, 64, 0, '0});
		plan.push_back('{ROW_ADD, 64, 1, 0, '0});
		plan.push_back('{ROW_ADD, 127, 5, 0, '0});
		plan.push_back('{ROW_ADD, 5, 127, 0, '0});
		plan.push_back('{ROW_ADD, 2, 3, 0, '0});
		plan.push_back('{ROW_ADD, 3, 2, 0, '0});
		plan.push_back('{ROW_RUN, 0, 0, 0, '0});
		plan.push_back('{ROW_CFG, 8, 0, 0, '0});
		plan.push_back('{ROW_ADD, 1, 2, 0, '0});
		plan.push_back('{ROW_ADD, 2, 3, 0, '0});
		plan.push_back('{ROW_ADD, 3, 1, 0, '0});
		plan.push_back('{ROW_ADD, 8, 7, 0, '0});
		plan.push_back('{ROW_ADD, 2, 8, 0, '0});
		plan.push_back('{ROW_CFG, 3, 0, 0, '0});
		plan.push_back('{ROW_RUN, 0, 0, 0, '0});
		plan.push_back('{ROW_CFG, 64, 0, 0, '0});

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			case (plan[i].kind)
				ROW_CFG: begin
					settle();
					write_count(plan[i].a);
				end
				ROW_ADD: send_request(scc_pkg::REQ_ADD, plan[i].a, plan[i].b, 0, '0);
				default: send_request(scc_pkg::REQ_RUN, 0, 0, plan[i].typed, plan[i].want);
			endcase
		end

		// Back-to-back graphs while the receiver holds off.
		settle();
		hold_left = 400;
		for (int g = 0; g < 4; g++)
			random_graph(64, $urandom_range(10, 30));

		// Random graphs; the last few run without any idling.
		for (int g = 0; g < 12; g++) begin
			calm = (g >= 9);
			if ($urandom_range(0, 2) != 0) begin
				settle();
				case ($urandom_range(0, 5))
					0:       n = 64;
					1:       n = 1;
					2:       n = $urandom_range(1, 64);
					default: n = $urandom_range(2, 12);
				endcase
				write_count(n);
			end
			n = (live_nodes() == 0) ? 1 : live_nodes();
			if ($urandom_range(0, 7) == 0) begin
				// Lower the count after loading so high targets are skipped.
				for (int i = 0; i < 10; i++)
					send_request(scc_pkg::REQ_ADD, $urandom_range(1, n),
						$urandom_range(1, n), 0, '0);
				settle();
				write_count($urandom_range(1, n));
				send_request(scc_pkg::REQ_RUN, 0, 0, 0, '0);
			end else begin
				random_graph(n, $urandom_range(0, 2 * n + 4));
			end
		end

		// Wind down and report.
		settle();
		$display("Sent %0d requests including %0d searches; checked %0d component members.",
			requests_sent, searches_sent, members_seen);
		$display("Covered node count extremes, dropped edges and output backpressure.");
		if (mismatches == 0 && pending_members.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches, %0d members missing", mismatches, pending_members.size());
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

@@ sim.f @@
src/scc_pkg.sv
src/scc_ram.sv
src/strongly_connected_components.sv
verif/strongly_connected_components_tb.sv
